### rtl/core/a7p_pkg.sv
package a7p_pkg;

    // held bytes per group and result cells in the output chain
    localparam int HoldLen = 7;
    localparam int OutLen  = HoldLen + 1;

    typedef logic [6:0] t_hold;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       status;
        logic       last_of_run;
    } t_item;

endpackage

### rtl/core/a7p_hold_cell.sv
module a7p_hold_cell
    import a7p_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_hold i_d,
    output t_hold o_q
);

    t_hold r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/core/a7p_out_cell.sv
module a7p_out_cell
    import a7p_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_move,
    input  logic  i_load,
    input  logic  i_load_valid,
    input  t_item i_load_item,
    input  logic  i_next_valid,
    input  t_item i_next_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_valid;
        end else if (i_move) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_load_item;
        end else if (i_move) begin
            r_item <= i_next_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/ascii_7bit_packer.sv
// results appear in the cycle after the transfer that completes a group or ends the stream
// throughput: one input byte per cycle; each group of eight bytes gives seven results and an end
// of stream up to eight, one a cycle while not stalled, from an eight-cell output chain
// input ready drops for an end of stream or a byte after seven held ones while the output
// chain holds two or more items or its head item is stalled
// reset: synchronous, active low; clears group count, error flag and output valid bits
module ascii_7bit_packer
    import a7p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // end_of_stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [0] is_status, [1] status
    output logic       o_m_axis_tlast    // last_of_run
);

    logic [2:0] r_count, n_count;
    logic       r_err, n_err;

    t_hold hold [HoldLen];
    logic  shift;

    logic  out_valid [OutLen];
    t_item out_item  [OutLen];
    logic  load_valid [OutLen];
    t_item load_item  [OutLen];

    logic accept, need_load, chain_free, move, load;
    logic [2:0] stat_pos;

    assign move       = !out_valid[0] || i_m_axis_tready;
    assign chain_free = !out_valid[1] && move;
    assign need_load  = i_s_axis_tlast || (r_count == 3'(HoldLen));
    assign o_s_axis_tready = !need_load || chain_free;
    assign accept     = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        shift   = 1'b0;
        load    = 1'b0;
        if (accept) begin
            if (i_s_axis_tlast) begin
                load    = 1'b1;
                n_count = '0;
                n_err   = 1'b0;
            end else if (r_err) begin
                n_count = r_count;
            end else if (i_s_axis_tdata[7]) begin
                n_err   = 1'b1;
                n_count = '0;
            end else if (r_count < 3'(HoldLen)) begin
                shift   = 1'b1;
                n_count = r_count + 3'd1;
            end else begin
                load    = 1'b1;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // newest byte enters cell 0; when full, cell j holds the byte that takes bit j of the eighth
    genvar g;
    generate
        for (g = 0; g < HoldLen; g++) begin : g_hold
            if (g == 0) begin : g_head
                a7p_hold_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (shift),
                    .i_d     (i_s_axis_tdata[6:0]),
                    .o_q     (hold[g])
                );
            end else begin : g_body
                a7p_hold_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (shift),
                    .i_d     (hold[g-1]),
                    .o_q     (hold[g])
                );
            end
        end
    endgenerate

    assign stat_pos = r_err ? 3'd0 : r_count;

    always_comb begin
        logic [2:0] idx;
        idx = '0;
        for (int k = 0; k < OutLen; k++) begin
            load_valid[k] = 1'b0;
            load_item[k]  = '0;
        end
        if (i_s_axis_tlast) begin
            for (int k = 0; k < OutLen; k++) begin
                idx = r_count - 3'(k) - 3'd1;
                if (!r_err && (3'(k) < r_count)) begin
                    load_valid[k]         = 1'b1;
                    load_item[k].out_byte = {1'b0, hold[idx]};
                end else if (3'(k) == stat_pos) begin
                    load_valid[k]            = 1'b1;
                    load_item[k].is_status   = 1'b1;
                    load_item[k].status      = r_err;
                    load_item[k].last_of_run = 1'b1;
                end
            end
        end else begin
            for (int k = 0; k < HoldLen; k++) begin
                load_valid[k]            = 1'b1;
                load_item[k].out_byte    = {i_s_axis_tdata[HoldLen-1-k], hold[HoldLen-1-k]};
                load_item[k].last_of_run = (k == HoldLen - 1);
            end
        end
    end

    generate
        for (g = 0; g < OutLen; g++) begin : g_out
            if (g == OutLen - 1) begin : g_tail
                a7p_out_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_move       (move),
                    .i_load       (load),
                    .i_load_valid (load_valid[g]),
                    .i_load_item  (load_item[g]),
                    .i_next_valid (1'b0),
                    .i_next_item  ('0),
                    .o_valid      (out_valid[g]),
                    .o_item       (out_item[g])
                );
            end else begin : g_body
                a7p_out_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_move       (move),
                    .i_load       (load),
                    .i_load_valid (load_valid[g]),
                    .i_load_item  (load_item[g]),
                    .i_next_valid (out_valid[g+1]),
                    .i_next_item  (out_item[g+1]),
                    .o_valid      (out_valid[g]),
                    .o_item       (out_item[g])
                );
            end
        end
    endgenerate

    assign o_m_axis_tvalid = out_valid[0];
    assign o_m_axis_tdata  = out_item[0].out_byte;
    assign o_m_axis_tuser  = {out_item[0].status, out_item[0].is_status};
    assign o_m_axis_tlast  = out_item[0].last_of_run;

    a_err_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_count == 3'd0))
        else $error("error flag set with bytes held");

    a_eos_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("end of stream transfer left no result");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("status item not marked last");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid[1] |-> out_valid[0])
        else $error("output chain has a gap at its head");

endmodule

### sim/tb.sv
module tb;
    import a7p_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int TotalItems  = 230;
    localparam int DrainCycles = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = '0;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    ascii_7bit_packer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),   // [7:0] in_byte
        .i_s_axis_tlast  (s_last),   // end_of_stream
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] out_byte
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] is_status, [1] status
        .o_m_axis_tlast  (o_m_axis_tlast)    // last_of_run
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_hold held_bytes [HoldLen];
    int    held_count = 0;
    bit    bad_byte_seen = 1'b0;
    t_item packed_q [$];

    int fail_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int gap_max = 6;
    int unsigned cycles = 0;

    task automatic push_result(input logic [7:0] b, input logic is_stat, input logic stat,
                               input logic last);
        t_item it;
        it.out_byte    = b;
        it.is_status   = is_stat;
        it.status      = stat;
        it.last_of_run = last;
        packed_q.push_back(it);
    endtask

    task automatic pack_byte(input logic [7:0] b, input logic eos);
        if (eos) begin
            if (!bad_byte_seen) begin
                for (int k = 0; k < held_count; k++)
                    push_result({1'b0, held_bytes[k]}, 1'b0, 1'b0, 1'b0);
            end
            push_result(8'h00, 1'b1, bad_byte_seen, 1'b1);
            held_count = 0;
            bad_byte_seen = 1'b0;
        end else if (bad_byte_seen) begin
            // ignored until the end marker
        end else if (b[7]) begin
            bad_byte_seen = 1'b1;
            held_count = 0;
        end else if (held_count < HoldLen) begin
            held_bytes[held_count] = b[6:0];
            held_count++;
        end else begin
            // eighth byte spreads its low seven bits over the held bytes, msb first
            for (int k = 0; k < HoldLen; k++)
                push_result({b[6 - k], held_bytes[k]}, 1'b0, 1'b0, k == HoldLen - 1);
            held_count = 0;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pack_byte(b, eos);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (packed_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_stream(input int n_bytes, input int err_at, input bit noise);
        logic [7:0] b;
        for (int i = 0; i < n_bytes; i++) begin
            if (i == err_at)
                b = 8'h80 | 8'($urandom_range(127, 0));
            else if (noise)
                b = 8'($urandom_range(255, 0));
            else
                b = 8'($urandom_range(127, 0));
            send_item(b, 1'b0);
        end
        send_item(8'($urandom_range(255, 0)), 1'b1);
    endtask

    task automatic send_random_stream;
        int n_bytes;
        int err_at;
        bit noise;
        n_bytes = 8 * $urandom_range(2, 0) + $urandom_range(7, 0);
        err_at  = ($urandom_range(4, 0) == 0) ? $urandom_range(n_bytes, 0) : -1;
        noise   = ($urandom_range(9, 0) == 0);
        send_stream(n_bytes, err_at, noise);
    endtask

    // extreme byte values in both the held bytes and the top-bit byte
    task automatic test_full_groups;
        repeat (7) send_item(8'h7F, 1'b0);
        send_item(8'h00, 1'b0);
        repeat (7) send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        // empty group at the end marker, in_byte ignored
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_tail;
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b0);
        send_item(8'h43, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_bad_byte;
        send_item(8'h31, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_back_to_back;
        int saved_gap;
        saved_gap = gap_max;
        gap_max = 0;
        repeat (3) send_stream(8 * $urandom_range(2, 1) + $urandom_range(7, 0), -1, 1'b0);
        gap_max = saved_gap;
    endtask

    task automatic test_random_streams;
        bit drained;
        drained = 1'b0;
        while (items_sent < TotalItems) begin
            send_random_stream();
            if (!drained && items_sent > TotalItems / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    // receiver: stall rate is redrawn now and again from 0, 20 or 60 percent
    int stall_left = 0;
    int stall_pct = 0;
    always @(posedge i_clk) begin
        if (cycles % 200 == 0) begin
            case ($urandom_range(2, 0))
                0: stall_pct = 0;
                1: stall_pct = 20;
                default: stall_pct = 60;
            endcase
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(99, 0) < stall_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(11, 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_item want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (packed_q.size() == 0) begin
                $display("%0t: unexpected transfer: data %h user %b last %b", $time,
                         o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                fail_count++;
            end else begin
                want = packed_q.pop_front();
                if (o_m_axis_tdata !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.out_byte, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== want.is_status) begin
                    $display("%0t: is_status expected %b actual %b", $time,
                             want.is_status, o_m_axis_tuser[0]);
                    fail_count++;
                end
                if (o_m_axis_tuser[1] !== want.status) begin
                    $display("%0t: status expected %b actual %b", $time,
                             want.status, o_m_axis_tuser[1]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last_of_run) begin
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             want.last_of_run, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_groups();
        test_tail();
        test_bad_byte();
        test_back_to_back();
        test_random_streams();
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && packed_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
